[design/pmtx_pkg.sv]
package pmtx_pkg;

    // Default number of message slots held in the tables
    localparam int MAX_SLOTS_DEFAULT = 32;

    // Period code asking for a single send
    localparam logic [15:0] PERIOD_ONE_SHOT = 16'hFFFF;
    localparam logic [15:0] PERIOD_DISABLED = 16'h0000;

    // Register reset values
    localparam logic [5:0]  ENTRY_COUNT_RESET = 6'd0;
    localparam logic [15:0] MAX_WAIT_RESET    = 16'd500;

    // Configuration register indexes
    localparam logic CFG_ENTRY_COUNT = 1'b0;
    localparam logic CFG_MAX_WAIT    = 1'b1;

    // Request action carried in s_tuser
    localparam logic ACT_SET_PERIOD = 1'b0;
    localparam logic ACT_PASS       = 1'b1;

    // Result kind carried in m_tuser
    localparam logic KIND_TRANSMIT = 1'b0;
    localparam logic KIND_SUMMARY  = 1'b1;

    // Widths of the packed stream payloads
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 24;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SUMMARY
    } sched_state_t;

endpackage

[design/periodic_message_tx_scheduler_unit.sv]
// Channel   | Direction | Handshake           | Payload
// ----------+-----------+---------------------+----------------------------------------------
// s_        | in        | s_tvalid / s_tready | tuser: action; tdata: slot, period_ms, now_ms
// m_        | out       | m_tvalid / m_tready | tuser: kind; tlast: last; tdata: tx_slot, wait_ms
// cfg_      | in        | cfg_valid/cfg_ready | cfg_index selects register, cfg_data value
//
// A set request is written to the table as it is accepted. A pass request is accepted, then
// scans min(entry_count, MAX_SLOTS) slots in turn through the single subtract/compare unit
// and then issues the summary; the request port stays low meanwhile.
// A due slot, and the summary too, hold while the output register waits on the consumer.
// Reset (aresetn, synchronous, active low) clears the table valid bits: every slot reads as
// disabled with a last-send time of zero, so no clearing sweep is needed.
module periodic_message_tx_scheduler_unit #(
    parameter int MAX_SLOTS = pmtx_pkg::MAX_SLOTS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // request channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [pmtx_pkg::S_TDATA_W-1:0] s_tdata,   // [4:0] slot, [20:5] period_ms,
                                                      // [52:21] now_ms, [55:53] zero
    input  logic                           s_tuser,   // [0] action
    // result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pmtx_pkg::M_TDATA_W-1:0] m_tdata,   // [4:0] tx_slot, [20:5] wait_ms,
                                                      // [23:21] zero
    output logic                           m_tuser,   // [0] kind
    output logic                           m_tlast,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_index,
    input  logic [15:0]                    cfg_data
);

    localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);
    localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;

    // Unpack the request
    logic [4:0]  s_slot;
    logic [15:0] s_period;
    logic [31:0] s_now;
    logic        s_accept;

    assign s_slot   = s_tdata[4:0];
    assign s_period = s_tdata[20:5];
    assign s_now    = s_tdata[52:21];
    assign s_accept = s_tvalid && s_tready;

    // Configuration registers
    logic [5:0]  entry_count_reg;
    logic [15:0] max_wait_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= pmtx_pkg::ENTRY_COUNT_RESET;
            max_wait_reg    <= pmtx_pkg::MAX_WAIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                pmtx_pkg::CFG_ENTRY_COUNT: entry_count_reg <= cfg_data[5:0];
                pmtx_pkg::CFG_MAX_WAIT:    max_wait_reg    <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // Sequencer state
    pmtx_pkg::sched_state_t state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      now_reg, now_next;
    logic [15:0]      wait_reg, wait_next;

    // Slot tables: memories with registered read, plus a valid bit per slot in each table
    logic [15:0]      period_mem [MAX_SLOTS];
    logic [31:0]      last_mem   [MAX_SLOTS];
    logic [15:0]      period_rd_reg;
    logic [31:0]      last_rd_reg;
    logic             period_vld_reg [MAX_SLOTS];
    logic             last_vld_reg   [MAX_SLOTS];

    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] set_addr;
    logic             set_en;
    logic             oneshot_clr;
    logic             last_wr;

    // Output register
    logic             m_tvalid_reg;
    logic [4:0]       out_slot_reg;
    logic [15:0]      out_wait_reg;
    logic             out_kind_reg;
    logic             out_last_reg;
    logic             out_load;
    logic [4:0]       out_slot;
    logic [15:0]      out_wait;
    logic             out_kind;
    logic             out_busy;

    // Slot evaluation unit
    logic [15:0]      cur_period;
    logic [31:0]      cur_last;
    logic [31:0]      elapsed;
    logic [32:0]      remain;
    logic             is_oneshot;
    logic             is_due;
    logic             need_tx;
    logic [15:0]      cand_wait;
    logic             last_slot;
    logic [CMP_W-1:0] ec_ext;
    logic [CMP_W-1:0] slot_ext;

    assign ec_ext   = CMP_W'(entry_count_reg);
    assign slot_ext = CMP_W'(s_slot);
    assign set_addr = IDX_W'(s_slot);

    assign cur_period = period_vld_reg[idx_reg] ? period_rd_reg : pmtx_pkg::PERIOD_DISABLED;
    assign cur_last   = last_vld_reg[idx_reg] ? last_rd_reg : 32'd0;
    assign elapsed    = now_reg - cur_last;
    // Borrow out of period - elapsed marks a slot past its period
    assign remain     = {17'd0, cur_period} - {1'b0, elapsed};
    assign is_oneshot = (cur_period == pmtx_pkg::PERIOD_ONE_SHOT);
    assign is_due     = remain[32];
    assign need_tx    = (cur_period != pmtx_pkg::PERIOD_DISABLED) && (is_oneshot || is_due);
    assign cand_wait  = is_due ? cur_period : remain[15:0];
    assign last_slot  = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign out_busy   = m_tvalid_reg && !m_tready;

    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        now_next    = now_reg;
        wait_next   = wait_reg;
        rd_addr     = idx_reg;
        set_en      = 1'b0;
        oneshot_clr = 1'b0;
        last_wr     = 1'b0;
        out_load    = 1'b0;
        out_slot    = 5'd0;
        out_wait    = 16'd0;
        out_kind    = pmtx_pkg::KIND_TRANSMIT;
        s_tready    = 1'b0;

        unique case (state_reg)
            pmtx_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                // keep slot 0 in the read register, ready for a pass
                rd_addr  = '0;
                if (s_accept) begin
                    if (s_tuser == pmtx_pkg::ACT_PASS) begin
                        idx_next  = '0;
                        now_next  = s_now;
                        wait_next = max_wait_reg;
                        // clamp the scan length to the table size
                        count_next = (ec_ext > CMP_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
                                                                 : CNT_W'(ec_ext);
                        if (entry_count_reg == 6'd0) begin
                            state_next = pmtx_pkg::ST_SUMMARY;
                        end else begin
                            state_next = pmtx_pkg::ST_SCAN;
                        end
                    end else begin
                        // drop writes beyond the table
                        set_en = (slot_ext < CMP_W'(MAX_SLOTS));
                    end
                end
            end

            pmtx_pkg::ST_SCAN: begin
                if (!(need_tx && out_busy)) begin
                    if (need_tx) begin
                        out_load = 1'b1;
                        out_slot = 5'(idx_reg);
                        out_kind = pmtx_pkg::KIND_TRANSMIT;
                    end
                    if (is_oneshot) begin
                        oneshot_clr = 1'b1;
                    end else if (cur_period != pmtx_pkg::PERIOD_DISABLED) begin
                        last_wr = is_due;
                        if (cand_wait < wait_reg) begin
                            wait_next = cand_wait;
                        end
                    end
                    // advance to the next slot
                    idx_next = idx_reg + IDX_W'(1);
                    rd_addr  = idx_reg + IDX_W'(1);
                    if (last_slot) begin
                        state_next = pmtx_pkg::ST_SUMMARY;
                    end
                end
            end

            pmtx_pkg::ST_SUMMARY: begin
                if (!out_busy) begin
                    out_load   = 1'b1;
                    out_kind   = pmtx_pkg::KIND_SUMMARY;
                    out_wait   = wait_reg;
                    state_next = pmtx_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = pmtx_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pmtx_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        count_reg <= count_next;
        now_reg   <= now_next;
        wait_reg  <= wait_next;
    end

    // Table storage
    always_ff @(posedge aclk) begin
        if (set_en) begin
            period_mem[set_addr] <= s_period;
        end
        period_rd_reg <= period_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (last_wr) begin
            last_mem[idx_reg] <= now_reg;
        end
        last_rd_reg <= last_mem[rd_addr];
    end

    // Valid bits: an invalid slot reads as disabled and never sent
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_SLOTS; i++) begin
                period_vld_reg[i] <= 1'b0;
                last_vld_reg[i]   <= 1'b0;
            end
        end else begin
            if (set_en) begin
                period_vld_reg[set_addr] <= 1'b1;
            end
            if (oneshot_clr) begin
                period_vld_reg[idx_reg] <= 1'b0;
            end
            if (last_wr) begin
                last_vld_reg[idx_reg] <= 1'b1;
            end
        end
    end

    // Output register: hold a result until the consumer takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_slot_reg <= out_slot;
            out_wait_reg <= out_wait;
            out_kind_reg <= out_kind;
            out_last_reg <= (out_kind == pmtx_pkg::KIND_SUMMARY);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'd0, out_wait_reg, out_slot_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

[design/pmtx_checker.sv]
module pmtx_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [pmtx_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                           s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [pmtx_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tuser,
    input logic                           m_tlast,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic                           cfg_index,
    input logic [15:0]                    cfg_data
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    // Only the summary closes a pass
    a_last_summary: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == pmtx_pkg::KIND_SUMMARY)))
        else $error("tlast does not match summary kind");

    // Transmit requests carry no wait; the summary carries no slot
    a_unused_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tuser == pmtx_pkg::KIND_TRANSMIT) ? (m_tdata[20:5] == 16'd0)
                                                            : (m_tdata[4:0] == 5'd0)))
        else $error("unused result field not zero");

    // A pass request keeps the port closed in the following cycle
    a_pass_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == pmtx_pkg::ACT_PASS) |=> !s_tready)
        else $error("request taken during a pass");

    // A set request yields no result on its own
    a_set_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == pmtx_pkg::ACT_SET_PERIOD) && !m_tvalid
            |=> !m_tvalid)
        else $error("result after a set request");

endmodule

bind periodic_message_tx_scheduler_unit pmtx_checker u_pmtx_checker (.*);

[dv/tx_schedule_checker.sv]
// Watches the request, result and register channels of the transmit scheduler,
// keeps its own copy of the slot tables and checks every result in order.
module tx_schedule_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [pmtx_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [pmtx_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           m_tuser,
    input  logic                           m_tlast,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic                           cfg_index,
    input  logic [15:0]                    cfg_data,
    output int                             mismatch_count,
    output int                             pending_results,
    output int                             transmit_count,
    output int                             summary_count
);

    localparam int SLOTS = pmtx_pkg::MAX_SLOTS_DEFAULT;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic        kind;
        logic [4:0]  tx_slot;
        logic [15:0] wait_ms;
        logic        last;
    } sched_result_t;

    sched_result_t due_results[$];

    logic [15:0] period_copy [SLOTS];
    logic [31:0] sent_at     [SLOTS];
    logic [5:0]  scan_count;
    logic [15:0] wait_cap;

    // Walk the scanned slots and queue the transmit requests and the summary
    task automatic schedule_pass(input logic [31:0] now);
        int          limit;
        logic [31:0] elapsed;
        logic [31:0] wait_acc;
        logic [15:0] p;
        limit = (int'(scan_count) > SLOTS) ? SLOTS : int'(scan_count);
        wait_acc = {16'd0, wait_cap};
        for (int i = 0; i < limit; i++) begin
            p = period_copy[i];
            if (p == pmtx_pkg::PERIOD_ONE_SHOT) begin
                due_results.push_back({pmtx_pkg::KIND_TRANSMIT, i[4:0], 16'd0, 1'b0});
                period_copy[i] = pmtx_pkg::PERIOD_DISABLED;
            end else if (p != pmtx_pkg::PERIOD_DISABLED) begin
                elapsed = now - sent_at[i];
                if (elapsed > {16'd0, p}) begin
                    due_results.push_back({pmtx_pkg::KIND_TRANSMIT, i[4:0], 16'd0, 1'b0});
                    sent_at[i] = now;
                    if ({16'd0, p} < wait_acc)
                        wait_acc = {16'd0, p};
                end else if ({16'd0, p} - elapsed < wait_acc) begin
                    wait_acc = {16'd0, p} - elapsed;
                end
            end
        end
        due_results.push_back({pmtx_pkg::KIND_SUMMARY, 5'd0, wait_acc[15:0], 1'b1});
    endtask

    always @(posedge aclk) begin : watch
        sched_result_t seen;
        sched_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                period_copy[i] = pmtx_pkg::PERIOD_DISABLED;
                sent_at[i] = 32'd0;
            end
            scan_count = pmtx_pkg::ENTRY_COUNT_RESET;
            wait_cap = pmtx_pkg::MAX_WAIT_RESET;
            due_results.delete();
            mismatch_count = 0;
            transmit_count = 0;
            summary_count = 0;
        end else begin
            // Results first: a summary may leave on the edge that takes the next request
            if (m_tvalid && m_tready) begin
                seen = {m_tuser, m_tdata[4:0], m_tdata[20:5], m_tlast};
                if (seen.kind == pmtx_pkg::KIND_SUMMARY)
                    summary_count++;
                else
                    transmit_count++;
                if (due_results.size() == 0) begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("unexpected result: kind %0d slot %0d wait %0d last %0d",
                                 seen.kind, seen.tx_slot, seen.wait_ms, seen.last);
                    mismatch_count++;
                end else begin
                    want = due_results.pop_front();
                    if (seen !== want) begin
                        if (mismatch_count < REPORT_LIMIT)
                            $display({"result mismatch: expected kind %0d slot %0d wait %0d ",
                                      "last %0d, got kind %0d slot %0d wait %0d last %0d"},
                                     want.kind, want.tx_slot, want.wait_ms, want.last,
                                     seen.kind, seen.tx_slot, seen.wait_ms, seen.last);
                        mismatch_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == pmtx_pkg::CFG_ENTRY_COUNT)
                    scan_count = cfg_data[5:0];
                else
                    wait_cap = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == pmtx_pkg::ACT_SET_PERIOD)
                    period_copy[s_tdata[4:0]] = s_tdata[20:5];
                else
                    schedule_pass(s_tdata[52:21]);
            end
        end
        pending_results = due_results.size();
    end

endmodule

[dv/testbench.sv]
module testbench;

    // Generous ceiling on the length of the run
    localparam int CYCLE_LIMIT = 400000;
    localparam int SEGMENTS = 6;
    localparam int SEG_REQUESTS = 33;
    // Drain the stream every so many random requests
    localparam int DRAIN_EVERY = 12;
    // Cycles to let a set request or a trailing pass settle once the queue is empty
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES = 40;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    // [4:0] slot, [20:5] period_ms, [52:21] now_ms, [55:53] zero
    logic [pmtx_pkg::S_TDATA_W-1:0] s_tdata;
    logic                           s_tuser;   // [0] action
    logic                           m_tvalid;
    logic                           m_tready;
    // [4:0] tx_slot, [20:5] wait_ms, [23:21] zero
    logic [pmtx_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           m_tuser;   // [0] kind
    logic                           m_tlast;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic                           cfg_index;
    logic [15:0]                    cfg_data;

    int mismatch_count;
    int pending_results;
    int transmit_count;
    int summary_count;

    int cycle_count = 0;
    int request_count = 0;
    int pass_count = 0;
    int setting_count = 0;

    // Pacing: chance in a hundred that either side holds off in a given cycle
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    // Mirror of entry_count, used only to steer slot choice into the scanned range
    int cur_count = 0;
    // Running millisecond clock for the pass requests
    logic [31:0] clock_ms = 32'd0;

    // Register settings for the random segments, extremes included
    int seg_count [SEGMENTS] = '{8, 32, 63, 5, 32, 17};
    int seg_wait  [SEGMENTS] = '{500, 65535, 100, 0, 1000, 300};

    periodic_message_tx_scheduler_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tx_schedule_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .transmit_count  (transmit_count),
        .summary_count   (summary_count)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending_results);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver side: stall at random, refreshed on every falling edge
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Present one request and hold it until the block takes it. Valid stays high on
    // return so that a back-to-back request needs no second assignment in the same step.
    task automatic send_request(input logic act, input logic [4:0] slot,
                                input logic [15:0] period, input logic [31:0] now);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {3'b000, now, period, slot};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        request_count++;
    endtask

    // Unused fields carry random values so that every bit is exercised
    task automatic set_period(input logic [4:0] slot, input logic [15:0] period);
        send_request(pmtx_pkg::ACT_SET_PERIOD, slot, period, $urandom());
    endtask

    task automatic run_pass(input logic [31:0] now);
        send_request(pmtx_pkg::ACT_PASS, 5'($urandom_range(0, 31)),
                     16'($urandom_range(0, 65535)), now);
        pass_count++;
    endtask

    // Drop valid, then hold until every expected result has arrived and the
    // block has had time to finish any set request behind it
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_results != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Register writes only ever land while the block is idle
    task automatic write_reg(input logic index, input logic [15:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        if (index == pmtx_pkg::CFG_ENTRY_COUNT)
            cur_count = int'(value[5:0]);
        setting_count++;
    endtask

    // Mostly well-formed traffic: periods that fall due within a few passes and a
    // clock that moves forward, with jumps, wraps and backward steps as noise
    task automatic random_request();
        int          pick;
        int          lim;
        logic [4:0]  slot;
        logic [15:0] period;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            lim = (cur_count > 32) ? 32 : cur_count;
            if (lim == 0)
                lim = 1;
            if ($urandom_range(0, 9) < 7)
                slot = 5'($urandom_range(0, lim - 1));
            else
                slot = 5'($urandom_range(0, 31));
            pick = $urandom_range(0, 99);
            if (pick < 40)
                period = 16'($urandom_range(1, 60));
            else if (pick < 55)
                period = pmtx_pkg::PERIOD_DISABLED;
            else if (pick < 70)
                period = pmtx_pkg::PERIOD_ONE_SHOT;
            else if (pick < 85)
                period = 16'($urandom_range(0, 65535));
            else
                period = 16'($urandom_range(61, 2000));
            set_period(slot, period);
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                clock_ms = clock_ms + $urandom_range(0, 80);
            else if (pick < 80)
                clock_ms = clock_ms + $urandom_range(0, 131071);
            else if (pick < 90)
                clock_ms = $urandom();
            else
                clock_ms = clock_ms - $urandom_range(1, 100);
            run_pass(clock_ms);
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = pmtx_pkg::ACT_SET_PERIOD;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = pmtx_pkg::CFG_ENTRY_COUNT;
        cfg_data  = 16'd0;

        // Hold reset, then release it on a falling edge
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part, under the first pacing mode
        tx_idle_pct = 33;
        rx_idle_pct = 83;

        // Reset settings: nothing scanned, summary reports the reset wait
        run_pass(32'd0);
        write_reg(pmtx_pkg::CFG_ENTRY_COUNT, 16'd32);
        set_period(5'd0, pmtx_pkg::PERIOD_ONE_SHOT);
        set_period(5'd1, 16'd10);
        set_period(5'd2, 16'd1);
        set_period(5'd31, 16'hFFFE);
        set_period(5'd7, 16'h5555);
        set_period(5'd8, 16'hAAAA);
        // Write then disable a slot
        set_period(5'd9, 16'd7);
        set_period(5'd9, pmtx_pkg::PERIOD_DISABLED);
        // Slot 1 sits exactly on its period: not due, wait drops to zero
        run_pass(32'd10);
        run_pass(32'd11);
        // Everything periodic due, then the clock wraps past zero
        run_pass(32'hFFFF_FFF0);
        run_pass(32'd3);
        // Re-arm the single send and clamp the wait to nothing
        set_period(5'd0, pmtx_pkg::PERIOD_ONE_SHOT);
        write_reg(pmtx_pkg::CFG_MAX_WAIT, 16'd0);
        run_pass(32'd4);
        write_reg(pmtx_pkg::CFG_MAX_WAIT, 16'hFFFF);
        run_pass(32'h8000_0000);
        // Entry count above the table size scans the whole table
        write_reg(pmtx_pkg::CFG_ENTRY_COUNT, 16'd63);
        run_pass(32'h8000_0005);
        write_reg(pmtx_pkg::CFG_ENTRY_COUNT, 16'd1);
        set_period(5'd0, pmtx_pkg::PERIOD_ONE_SHOT);
        run_pass(32'h8000_0006);
        run_pass(32'h8000_0007);

        // Random segments, each under its own register setting and pacing mode
        clock_ms = $urandom();
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg < 2) begin
                tx_idle_pct = 33;
                rx_idle_pct = 83;
            end else if (seg < 4) begin
                tx_idle_pct = 83;
                rx_idle_pct = 33;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            write_reg(pmtx_pkg::CFG_ENTRY_COUNT, 16'(seg_count[seg]));
            write_reg(pmtx_pkg::CFG_MAX_WAIT, 16'(seg_wait[seg]));
            for (int k = 0; k < SEG_REQUESTS; k++) begin
                random_request();
                // Pause the sender until the stream has drained
                if (k % DRAIN_EVERY == DRAIN_EVERY - 1)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge aclk);

        $display({"covered %0d requests (%0d passes) over %0d register writes ",
                  "and three pacing modes"},
                 request_count, pass_count, setting_count);
        $display("checked %0d transmit and %0d summary results, %0d mismatches",
                 transmit_count, summary_count, mismatch_count);
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
